// ===== rtl/apic_tmr_pkg.sv =====
`timescale 1ns / 1ps

package apic_tmr_pkg;

  localparam int TMR_COUNT_BITS = 32;

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2
  } func_t;

  // register byte offsets
  localparam logic [9:0] OFS_EOI  = 10'h0B0;
  localparam logic [9:0] OFS_SPUR = 10'h0F0;
  localparam logic [9:0] OFS_TLVT = 10'h320;
  localparam logic [9:0] OFS_ELVT = 10'h370;
  localparam logic [9:0] OFS_INIT = 10'h380;
  localparam logic [9:0] OFS_CUR  = 10'h390;
  localparam logic [9:0] OFS_DIV  = 10'h3E0;

  localparam logic [3:0]  DIV_MASK      = 4'b1011;
  localparam logic [8:0]  SPUR_RESET    = 9'h0FF;
  localparam int          LVT_MASK_BIT  = 16;
  localparam int          LVT_PER_BIT   = 17;
  localparam int          SPUR_EN_BIT   = 8;

  typedef struct packed {
    logic [1:0]  func;
    logic [9:0]  reg_offset;
    logic [31:0] write_data;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        timer_fire;
    logic [7:0]  fire_vector;
  } result_t;

  // ticks per count period; code 4'b1011 divides by one
  function automatic logic [7:0] div_ratio(input logic [3:0] code);
    logic [2:0] c;
    c = {code[3], code[1:0]};
    if (c == 3'd7) begin
      return 8'd1;
    end
    return 8'd2 << c;
  endfunction

endpackage

// ===== rtl/apic_timer_countdown.sv =====
`timescale 1ns / 1ps

// Channel  Ports           tdata (low bit up)                         tuser
// in       in_t*   (48b)   reg_offset[9:0], write_data[41:10], zeros    func[1:0]
// out      out_t*  (48b)   read_data[31:0], timer_fire[32],            -
//                          fire_vector[40:33], zeros
//
// One word per cycle sustained while the output is not stalled. A word is captured in the input register,
// then the register file and countdown update and the result register loads.
// out_tvalid rises when the result register loads.
// rst_n (synchronous) restores the reset register values and empties both stages.
// A stalled output holds the result; the input stage still drains into it when
// it empties in the same cycle.

module apic_timer_countdown #(
  parameter int COUNT_BITS = apic_tmr_pkg::TMR_COUNT_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [apic_tmr_pkg::IN_DATA_W-1:0] in_tdata,  // reg_offset, write_data
  input  logic [apic_tmr_pkg::IN_USER_W-1:0] in_tuser,  // func
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [apic_tmr_pkg::OUT_DATA_W-1:0] out_tdata // read_data, timer_fire, fire_vector
);

  logic                  in_vld_r;
  apic_tmr_pkg::item_t   in_item_r;
  logic                  out_vld_r;
  apic_tmr_pkg::result_t out_res_r;
  apic_tmr_pkg::result_t res;
  logic                  advance;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.func       <= in_tuser;
      in_item_r.reg_offset <= in_tdata[9:0];
      in_item_r.write_data <= in_tdata[41:10];
    end
  end

  apic_tmr_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_item_r),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_res_r.fire_vector, out_res_r.timer_fire,
                       out_res_r.read_data};

endmodule

// ===== rtl/apic_tmr_core.sv =====
`timescale 1ns / 1ps

module apic_tmr_core #(
  parameter int COUNT_BITS = apic_tmr_pkg::TMR_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  apic_tmr_pkg::item_t   item,
  output apic_tmr_pkg::result_t result
);

  logic [3:0]            divide_code_r, divide_code_nxt;
  logic [7:0]            tlvt_vec_r, tlvt_vec_nxt;
  logic                  tlvt_mask_r, tlvt_mask_nxt;
  logic                  tlvt_per_r, tlvt_per_nxt;
  logic [COUNT_BITS-1:0] initial_count_r, initial_count_nxt;
  logic [COUNT_BITS-1:0] current_count_r, current_count_nxt;
  logic [6:0]            prescaler_r, prescaler_nxt;
  logic [8:0]            spurious_r, spurious_nxt;
  logic [7:0]            elvt_vec_r, elvt_vec_nxt;
  logic                  elvt_mask_r, elvt_mask_nxt;
  logic                  in_service_r, in_service_nxt;

  logic [7:0]            pre_inc;
  logic                  period_done;
  logic [COUNT_BITS-1:0] count_dec;

  assign pre_inc     = {1'b0, prescaler_r} + 8'd1;
  assign period_done = pre_inc >= apic_tmr_pkg::div_ratio(divide_code_r);
  assign count_dec   = current_count_r - {{(COUNT_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    divide_code_nxt   = divide_code_r;
    tlvt_vec_nxt      = tlvt_vec_r;
    tlvt_mask_nxt     = tlvt_mask_r;
    tlvt_per_nxt      = tlvt_per_r;
    initial_count_nxt = initial_count_r;
    current_count_nxt = current_count_r;
    prescaler_nxt     = prescaler_r;
    spurious_nxt      = spurious_r;
    elvt_vec_nxt      = elvt_vec_r;
    elvt_mask_nxt     = elvt_mask_r;
    in_service_nxt    = in_service_r;
    result            = '0;
    unique case (apic_tmr_pkg::func_t'(item.func))
      apic_tmr_pkg::FUNC_TICK: begin
        prescaler_nxt = period_done ? 7'd0 : pre_inc[6:0];
        if (period_done && (current_count_r != '0)) begin
          current_count_nxt = count_dec;
          if (count_dec == '0) begin
            if (!tlvt_mask_r && spurious_r[apic_tmr_pkg::SPUR_EN_BIT]) begin
              result.timer_fire  = 1'b1;
              result.fire_vector = tlvt_vec_r;
              in_service_nxt     = 1'b1;
            end
            // periodic mode: reload
            if (tlvt_per_r) begin
              current_count_nxt = initial_count_r;
            end
          end
        end
      end
      apic_tmr_pkg::FUNC_WRITE: begin
        unique case (item.reg_offset)
          apic_tmr_pkg::OFS_EOI:  in_service_nxt = 1'b0;
          apic_tmr_pkg::OFS_SPUR: spurious_nxt = item.write_data[8:0];
          apic_tmr_pkg::OFS_TLVT: begin
            tlvt_vec_nxt  = item.write_data[7:0];
            tlvt_mask_nxt = item.write_data[apic_tmr_pkg::LVT_MASK_BIT];
            tlvt_per_nxt  = item.write_data[apic_tmr_pkg::LVT_PER_BIT];
          end
          apic_tmr_pkg::OFS_ELVT: begin
            elvt_vec_nxt  = item.write_data[7:0];
            elvt_mask_nxt = item.write_data[apic_tmr_pkg::LVT_MASK_BIT];
          end
          apic_tmr_pkg::OFS_INIT: begin
            initial_count_nxt = item.write_data[COUNT_BITS-1:0];
            current_count_nxt = item.write_data[COUNT_BITS-1:0];
            prescaler_nxt     = 7'd0;
          end
          apic_tmr_pkg::OFS_DIV:
            divide_code_nxt = item.write_data[3:0] & apic_tmr_pkg::DIV_MASK;
          default: ;
        endcase
      end
      apic_tmr_pkg::FUNC_READ: begin
        unique case (item.reg_offset)
          apic_tmr_pkg::OFS_SPUR: result.read_data = {23'd0, spurious_r};
          apic_tmr_pkg::OFS_TLVT:
            result.read_data = {14'd0, tlvt_per_r, tlvt_mask_r, 8'd0, tlvt_vec_r};
          apic_tmr_pkg::OFS_ELVT:
            result.read_data = {15'd0, elvt_mask_r, 8'd0, elvt_vec_r};
          apic_tmr_pkg::OFS_INIT: result.read_data = 32'(initial_count_r);
          apic_tmr_pkg::OFS_CUR:  result.read_data = 32'(current_count_r);
          apic_tmr_pkg::OFS_DIV:  result.read_data = {28'd0, divide_code_r};
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divide_code_r   <= 4'd0;
      tlvt_vec_r      <= 8'd0;
      tlvt_mask_r     <= 1'b1;
      tlvt_per_r      <= 1'b0;
      initial_count_r <= '0;
      current_count_r <= '0;
      prescaler_r     <= 7'd0;
      spurious_r      <= apic_tmr_pkg::SPUR_RESET;
      elvt_vec_r      <= 8'd0;
      elvt_mask_r     <= 1'b1;
      in_service_r    <= 1'b0;
    end else if (step) begin
      divide_code_r   <= divide_code_nxt;
      tlvt_vec_r      <= tlvt_vec_nxt;
      tlvt_mask_r     <= tlvt_mask_nxt;
      tlvt_per_r      <= tlvt_per_nxt;
      initial_count_r <= initial_count_nxt;
      current_count_r <= current_count_nxt;
      prescaler_r     <= prescaler_nxt;
      spurious_r      <= spurious_nxt;
      elvt_vec_r      <= elvt_vec_nxt;
      elvt_mask_r     <= elvt_mask_nxt;
      in_service_r    <= in_service_nxt;
    end
  end

endmodule

// ===== rtl/apic_tmr_checker.sv =====
`timescale 1ns / 1ps

module apic_tmr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  logic [1:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 2'd0)
    else $error("result without a pending word");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more words in flight than stages");

  a_fire_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] |-> out_tdata[31:0] == 32'd0)
    else $error("fire reported together with read data");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

endmodule

bind apic_timer_countdown apic_tmr_checker u_apic_tmr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
